FILE: design/rlnt_pkg.sv
// rlnt_pkg: shared types and constants for the route leg netting table.
// Holds the request and row word layouts; no dependencies.
package rlnt_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int AMT_W             = 64;
	localparam int KEY_W             = 4 * AMT_W;

	localparam logic REQ_LEG   = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [AMT_W-1:0] in_key_w0;
		logic [AMT_W-1:0] in_key_w1;
		logic [AMT_W-1:0] in_key_w2;
		logic [AMT_W-1:0] in_key_w3;
		logic [AMT_W-1:0] in_amount;
		logic [AMT_W-1:0] out_key_w0;
		logic [AMT_W-1:0] out_key_w1;
		logic [AMT_W-1:0] out_key_w2;
		logic [AMT_W-1:0] out_key_w3;
		logic [AMT_W-1:0] out_amount;
	} req_t;

	typedef struct packed {
		logic             row_valid;
		logic [AMT_W-1:0] paid_key_w0;
		logic [AMT_W-1:0] paid_key_w1;
		logic [AMT_W-1:0] paid_key_w2;
		logic [AMT_W-1:0] paid_key_w3;
		logic [AMT_W-1:0] paid_net;
		logic [AMT_W-1:0] got_key_w0;
		logic [AMT_W-1:0] got_key_w1;
		logic [AMT_W-1:0] got_key_w2;
		logic [AMT_W-1:0] got_key_w3;
		logic [AMT_W-1:0] got_net;
	} rsp_t;

endpackage

FILE: design/route_leg_netting_table.sv
// route_leg_netting_table: keyed netting table with a single-port search/scan sequencer.
// Depends on rlnt_pkg for the request and row word types.
//
// Accepts one request word at a time; req_ready is low while a request is worked on.
// A leg word searches the table once per key, one entry per cycle through the key
// memory's single read port, then updates that key's sum in a read and a write state.
// A flush after legs with no overflow scans the sum memories one entry per cycle, then
// reads both picked keys if both nets are nonzero; any other flush emits an empty row.
// A flush may wait for the row register to drain. The row register lets leg words
// proceed while a row is pending.
// No clearing pass is needed after reset; the table is emptied by resetting its fill count.
module route_leg_netting_table #(
	parameter int TABLE_ENTRIES = rlnt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rlnt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rlnt_pkg::rsp_t rsp
);

	localparam int IW    = $clog2(TABLE_ENTRIES);
	localparam int CW    = $clog2(TABLE_ENTRIES + 1);
	localparam int KEY_W = rlnt_pkg::KEY_W;
	localparam int AMT_W = rlnt_pkg::AMT_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SEARCH  = 3'd1;
	localparam logic [2:0] ST_UPD_RD  = 3'd2;
	localparam logic [2:0] ST_UPD_WR  = 3'd3;
	localparam logic [2:0] ST_SCAN    = 3'd4;
	localparam logic [2:0] ST_FETCH_P = 3'd5;
	localparam logic [2:0] ST_FETCH_G = 3'd6;
	localparam logic [2:0] ST_EMIT    = 3'd7;

	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	logic [2:0]       state_q;
	logic [CW-1:0]    used_q;
	logic             overflowed_q;
	logic             leg_seen_q;
	logic [CW-1:0]    rd_idx_q;
	logic             pend_q;
	logic [IW-1:0]    pend_idx_q;
	logic             side_q;
	logic             new_q;
	logic [IW-1:0]    slot_q;
	logic             row_ok_q;
	rlnt_pkg::req_t   req_q;

	logic [AMT_W-1:0] paid_net_q, got_net_q;
	logic [IW-1:0]    paid_at_q, got_at_q;
	logic [KEY_W-1:0] paid_key_q;

	logic             rsp_valid_q;
	rlnt_pkg::rsp_t   rsp_q;

	logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
	logic [AMT_W-1:0] in_mem  [TABLE_ENTRIES];
	logic [AMT_W-1:0] out_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0] key_rd_q;
	logic [AMT_W-1:0] in_rd_q, out_rd_q;

	logic [IW-1:0]    key_ra, sum_ra;
	logic             key_we, in_we, out_we;
	logic [AMT_W-1:0] in_wd, out_wd;

	logic [KEY_W-1:0] side_key;
	logic [AMT_W-1:0] side_amt;
	logic             issue;
	logic             hit;
	logic             scan_done;
	logic [AMT_W-1:0] upd_base, upd_sum;
	logic [AMT_W:0]   diff;
	logic [AMT_W-1:0] net_p, net_g;
	logic             is_p, is_g;
	logic             emit_go;
	logic             accept;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign side_key = side_q ?
		{req_q.out_key_w3, req_q.out_key_w2, req_q.out_key_w1, req_q.out_key_w0} :
		{req_q.in_key_w3, req_q.in_key_w2, req_q.in_key_w1, req_q.in_key_w0};
	assign side_amt = side_q ? req_q.out_amount : req_q.in_amount;

	assign issue     = (rd_idx_q < used_q);
	assign hit       = pend_q && (key_rd_q == side_key);
	assign scan_done = !pend_q && !issue;

	// shared adder for leg updates
	assign upd_base = new_q ? '0 : (side_q ? out_rd_q : in_rd_q);
	assign upd_sum  = upd_base + side_amt;

	// shared subtractor for the flush scan
	assign diff  = {1'b0, in_rd_q} - {1'b0, out_rd_q};
	assign is_p  = !diff[AMT_W] && (diff[AMT_W-1:0] != '0);
	assign is_g  = diff[AMT_W];
	assign net_p = diff[AMT_W-1:0];
	assign net_g = '0 - diff[AMT_W-1:0];

	assign emit_go = (state_q == ST_EMIT) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		key_ra = rd_idx_q[IW-1:0];
		sum_ra = rd_idx_q[IW-1:0];
		unique case (state_q)
			ST_UPD_RD, ST_UPD_WR: begin
				sum_ra = slot_q;
			end
			ST_FETCH_P: begin
				key_ra = paid_at_q;
			end
			ST_FETCH_G, ST_EMIT: begin
				key_ra = got_at_q;
			end
			default: begin
				key_ra = rd_idx_q[IW-1:0];
			end
		endcase
	end

	always_comb begin
		key_we = (state_q == ST_SEARCH) && !hit && scan_done && (used_q != FULL);
		in_we  = (state_q == ST_UPD_WR) && (!side_q || new_q);
		out_we = (state_q == ST_UPD_WR) && (side_q || new_q);
		in_wd  = side_q ? '0 : upd_sum;
		out_wd = side_q ? upd_sum : '0;
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[used_q[IW-1:0]] <= side_key;
		end
		key_rd_q <= key_mem[key_ra];
	end

	always_ff @(posedge clk) begin
		if (in_we) begin
			in_mem[slot_q] <= in_wd;
		end
		in_rd_q <= in_mem[sum_ra];
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			out_mem[slot_q] <= out_wd;
		end
		out_rd_q <= out_mem[sum_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			overflowed_q <= 1'b0;
			leg_seen_q   <= 1'b0;
			rd_idx_q     <= '0;
			pend_q       <= 1'b0;
			side_q       <= 1'b0;
			new_q        <= 1'b0;
			row_ok_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					pend_q   <= 1'b0;
					side_q   <= 1'b0;
					if (accept) begin
						if (req.req_type == rlnt_pkg::REQ_LEG) begin
							leg_seen_q <= 1'b1;
							state_q    <= ST_SEARCH;
						end else if (leg_seen_q && !overflowed_q) begin
							state_q <= ST_SCAN;
						end else begin
							row_ok_q <= 1'b0;
							state_q  <= ST_EMIT;
						end
					end
				end
				ST_SEARCH: begin
					pend_q <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (hit) begin
						new_q   <= 1'b0;
						state_q <= ST_UPD_RD;
					end else if (scan_done) begin
						if (used_q == FULL) begin
							overflowed_q <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							used_q  <= used_q + 1'b1;
							new_q   <= 1'b1;
							state_q <= ST_UPD_RD;
						end
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_WR;
				end
				ST_UPD_WR: begin
					rd_idx_q <= '0;
					pend_q   <= 1'b0;
					if (side_q) begin
						state_q <= ST_IDLE;
					end else begin
						side_q  <= 1'b1;
						state_q <= ST_SEARCH;
					end
				end
				ST_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (scan_done) begin
						row_ok_q <= (paid_net_q != '0) && (got_net_q != '0);
						if ((paid_net_q != '0) && (got_net_q != '0)) begin
							state_q <= ST_FETCH_P;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_FETCH_P: begin
					state_q <= ST_FETCH_G;
				end
				ST_FETCH_G: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						used_q       <= '0;
						overflowed_q <= 1'b0;
						leg_seen_q   <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req;
			paid_net_q <= '0;
			got_net_q  <= '0;
			paid_at_q  <= '0;
			got_at_q   <= '0;
		end
		if (issue && (state_q == ST_SEARCH || state_q == ST_SCAN)) begin
			pend_idx_q <= rd_idx_q[IW-1:0];
		end
		if (state_q == ST_SEARCH) begin
			if (hit) begin
				slot_q <= pend_idx_q;
			end else if (scan_done) begin
				slot_q <= used_q[IW-1:0];
			end
		end
		if (state_q == ST_SCAN && pend_q) begin
			if (is_p && (net_p > paid_net_q)) begin
				paid_net_q <= net_p;
				paid_at_q  <= pend_idx_q;
			end
			if (is_g && (net_g > got_net_q)) begin
				got_net_q <= net_g;
				got_at_q  <= pend_idx_q;
			end
		end
		if (state_q == ST_FETCH_G) begin
			paid_key_q <= key_rd_q;
		end
		if (emit_go) begin
			if (row_ok_q) begin
				rsp_q.row_valid   <= 1'b1;
				rsp_q.paid_key_w0 <= paid_key_q[AMT_W-1:0];
				rsp_q.paid_key_w1 <= paid_key_q[2*AMT_W-1:AMT_W];
				rsp_q.paid_key_w2 <= paid_key_q[3*AMT_W-1:2*AMT_W];
				rsp_q.paid_key_w3 <= paid_key_q[4*AMT_W-1:3*AMT_W];
				rsp_q.paid_net    <= paid_net_q;
				rsp_q.got_key_w0  <= key_rd_q[AMT_W-1:0];
				rsp_q.got_key_w1  <= key_rd_q[2*AMT_W-1:AMT_W];
				rsp_q.got_key_w2  <= key_rd_q[3*AMT_W-1:2*AMT_W];
				rsp_q.got_key_w3  <= key_rd_q[4*AMT_W-1:3*AMT_W];
				rsp_q.got_net     <= got_net_q;
			end else begin
				rsp_q <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL)
		else $error("table fill count beyond capacity");

	a_valid_row_nets: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.row_valid |-> (rsp_q.paid_net != '0) && (rsp_q.got_net != '0))
		else $error("valid row with a zero net");

	a_invalid_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.row_valid |-> (rsp_q.paid_net == '0) && (rsp_q.got_net == '0))
		else $error("invalid row carries nonzero nets");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (used_q == '0) && !leg_seen_q && !overflowed_q && rsp_valid_q)
		else $error("flush did not clear the table");

	a_append_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> used_q < FULL)
		else $error("append into a full table");
`endif

endmodule

FILE: tb/route_leg_netting_table_tb.sv
`timescale 1ns / 1ps
// route_leg_netting_table_tb: self-checking bench for the route leg netting table.
// Depends on rlnt_pkg and route_leg_netting_table; nets every accepted word in a local
// table and checks each flushed row field by field.
module route_leg_netting_table_tb;

	localparam int NUM_ENTRIES  = rlnt_pkg::TABLE_ENTRIES_DEF;
	localparam int KEY_W        = rlnt_pkg::KEY_W;
	localparam int AMT_W        = rlnt_pkg::AMT_W;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 2 * NUM_ENTRIES + 40;
	localparam int RANDOM_WORDS = 600;

	typedef struct {
		rlnt_pkg::req_t word;
		int             reps;
		bit             pinned;
		rlnt_pkg::rsp_t row;
	} plan_row_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	rlnt_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_ready;
	rlnt_pkg::rsp_t rsp;

	logic [KEY_W-1:0] net_key [NUM_ENTRIES];
	logic [AMT_W-1:0] net_in  [NUM_ENTRIES];
	logic [AMT_W-1:0] net_out [NUM_ENTRIES];
	int net_used;
	bit net_ovf;
	bit net_seen;

	rlnt_pkg::rsp_t row_q[$];
	plan_row_t      leg_plan[$];
	bit             pin_valid;
	rlnt_pkg::rsp_t pin_row;
	bit             hold_rx;
	int             tx_run;
	int             errors, idle_cycles, words_sent, legs_done, flushes_done;
	int             rows_checked, rows_netted, rows_ovf;

	route_leg_netting_table #(
		.TABLE_ENTRIES(NUM_ENTRIES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	function automatic rlnt_pkg::req_t mk_word(logic kind, logic [KEY_W-1:0] ik,
	                                           logic [AMT_W-1:0] ia,
	                                           logic [KEY_W-1:0] ok, logic [AMT_W-1:0] oa);
		rlnt_pkg::req_t w;
		w.req_type = kind;
		{w.in_key_w3, w.in_key_w2, w.in_key_w1, w.in_key_w0} = ik;
		w.in_amount = ia;
		{w.out_key_w3, w.out_key_w2, w.out_key_w1, w.out_key_w0} = ok;
		w.out_amount = oa;
		return w;
	endfunction

	function automatic rlnt_pkg::rsp_t mk_row(logic v, logic [KEY_W-1:0] pk,
	                                          logic [AMT_W-1:0] pn,
	                                          logic [KEY_W-1:0] gk, logic [AMT_W-1:0] gn);
		rlnt_pkg::rsp_t r;
		r.row_valid = v;
		{r.paid_key_w3, r.paid_key_w2, r.paid_key_w1, r.paid_key_w0} = pk;
		r.paid_net = pn;
		{r.got_key_w3, r.got_key_w2, r.got_key_w1, r.got_key_w0} = gk;
		r.got_net = gn;
		return r;
	endfunction

	function automatic bit find_slot(input logic [KEY_W-1:0] k, output int slot);
		slot = 0;
		for (int i = 0; i < net_used; i++) begin
			if (net_key[i] == k) begin
				slot = i;
				return 1'b1;
			end
		end
		if (net_used >= NUM_ENTRIES)
			return 1'b0;
		slot = net_used;
		net_key[slot] = k;
		net_in[slot]  = '0;
		net_out[slot] = '0;
		net_used++;
		return 1'b1;
	endfunction

	// advance the local table by one word; returns 1 when the word yields a row
	function automatic bit net_word(input rlnt_pkg::req_t w, output rlnt_pkg::rsp_t row);
		int slot;
		int paid_at, got_at;
		bit have_paid, have_got;
		logic [AMT_W-1:0] a, b, paid_net, got_net;
		row = '0;
		if (w.req_type == rlnt_pkg::REQ_LEG) begin
			net_seen = 1'b1;
			legs_done++;
			if (!find_slot({w.in_key_w3, w.in_key_w2, w.in_key_w1, w.in_key_w0}, slot)) begin
				net_ovf = 1'b1;
			end else begin
				net_in[slot] += w.in_amount;
				if (!find_slot({w.out_key_w3, w.out_key_w2, w.out_key_w1, w.out_key_w0}, slot))
					net_ovf = 1'b1;
				else
					net_out[slot] += w.out_amount;
			end
			return 1'b0;
		end
		flushes_done++;
		if (net_ovf)
			rows_ovf++;
		paid_at = 0;
		got_at = 0;
		have_paid = 1'b0;
		have_got = 1'b0;
		paid_net = '0;
		got_net = '0;
		if (net_seen && !net_ovf) begin
			for (int i = 0; i < net_used; i++) begin
				a = net_in[i];
				b = net_out[i];
				if (a > b) begin
					if (a - b > paid_net) begin
						paid_net = a - b;
						paid_at = i;
						have_paid = 1'b1;
					end
				end else if (b > a) begin
					if (b - a > got_net) begin
						got_net = b - a;
						got_at = i;
						have_got = 1'b1;
					end
				end
			end
			if (have_paid && have_got)
				row = mk_row(1'b1, net_key[paid_at], paid_net, net_key[got_at], got_net);
		end
		net_used = 0;
		net_ovf = 1'b0;
		net_seen = 1'b0;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [AMT_W-1:0] seen,
	                             input logic [AMT_W-1:0] want);
		$display("%0t mismatch %s: got %h, expected %h", $time, what, seen, want);
		errors++;
	endtask

	task automatic check_row(input rlnt_pkg::rsp_t seen, input rlnt_pkg::rsp_t want);
		if (seen.row_valid !== want.row_valid)
			flag_mismatch("row_valid", seen.row_valid, want.row_valid);
		if (seen.paid_key_w0 !== want.paid_key_w0)
			flag_mismatch("paid_key_w0", seen.paid_key_w0, want.paid_key_w0);
		if (seen.paid_key_w1 !== want.paid_key_w1)
			flag_mismatch("paid_key_w1", seen.paid_key_w1, want.paid_key_w1);
		if (seen.paid_key_w2 !== want.paid_key_w2)
			flag_mismatch("paid_key_w2", seen.paid_key_w2, want.paid_key_w2);
		if (seen.paid_key_w3 !== want.paid_key_w3)
			flag_mismatch("paid_key_w3", seen.paid_key_w3, want.paid_key_w3);
		if (seen.paid_net !== want.paid_net)
			flag_mismatch("paid_net", seen.paid_net, want.paid_net);
		if (seen.got_key_w0 !== want.got_key_w0)
			flag_mismatch("got_key_w0", seen.got_key_w0, want.got_key_w0);
		if (seen.got_key_w1 !== want.got_key_w1)
			flag_mismatch("got_key_w1", seen.got_key_w1, want.got_key_w1);
		if (seen.got_key_w2 !== want.got_key_w2)
			flag_mismatch("got_key_w2", seen.got_key_w2, want.got_key_w2);
		if (seen.got_key_w3 !== want.got_key_w3)
			flag_mismatch("got_key_w3", seen.got_key_w3, want.got_key_w3);
		if (seen.got_net !== want.got_net)
			flag_mismatch("got_net", seen.got_net, want.got_net);
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		for (int i = 0; i < KEY_W / 32; i++)
			k[32*i +: 32] = $urandom;
		return k;
	endfunction

	function automatic logic [AMT_W-1:0] rand_amt();
		case ($urandom_range(0, 3))
			0: return 64'($urandom_range(0, 15));
			1: return {$urandom, $urandom};
			2: return ~64'(0) - 64'($urandom_range(0, 15));
			default: return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic void plan(rlnt_pkg::req_t w, int reps, bit pinned, rlnt_pkg::rsp_t row);
		leg_plan.push_back('{word: w, reps: reps, pinned: pinned, row: row});
	endfunction

	task automatic send_word(input rlnt_pkg::req_t w, input bit pinned,
	                         input rlnt_pkg::rsp_t pin);
		int gap;
		if (tx_run > 0) begin
			gap = 0;
			tx_run--;
		end else if ($urandom_range(0, 15) == 0) begin
			gap = 0;
			tx_run = $urandom_range(10, 30);
		end else begin
			gap = $urandom_range(0, 5);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		pin_valid = pinned;
		pin_row = pin;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	always @(posedge clk) begin : watch
		rlnt_pkg::rsp_t next_row;
		rlnt_pkg::rsp_t want;
		if (rsp_valid && rsp_ready) begin
			rows_checked++;
			if (row_q.size() == 0) begin
				flag_mismatch("row word with none pending", rsp.row_valid, '0);
			end else begin
				want = row_q.pop_front();
				check_row(rsp, want);
			end
		end
		if (req_valid && req_ready) begin
			if (net_word(req, next_row)) begin
				if (pin_valid)
					next_row = pin_row;
				if (next_row.row_valid)
					rows_netted++;
				row_q.push_back(next_row);
			end
		end
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without a word moving", IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : drain_side
		int stall;
		int run;
		run = 0;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_rx) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rx = 1'b0;
			end else begin
				if (run > 0) begin
					stall = 0;
					run--;
				end else if ($urandom_range(0, 15) == 0) begin
					stall = 0;
					run = $urandom_range(5, 20);
				end else begin
					stall = $urandom_range(0, 5);
				end
				if (stall > 0) begin
					rsp_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : feed_side
		rlnt_pkg::rsp_t zero_row;
		rlnt_pkg::req_t w;
		logic [KEY_W-1:0] k_ones, ka, kb, kc, kd, kfa, kfb, ik, ok;
		logic [KEY_W-1:0] pool [6];
		int first_random, n, kind, npool;
		bit paused, held;

		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		hold_rx = 1'b0;
		pin_valid = 1'b0;
		pin_row = '0;
		tx_run = 0;
		net_used = 0;
		net_ovf = 1'b0;
		net_seen = 1'b0;
		paused = 1'b0;
		held = 1'b0;
		zero_row = '0;

		k_ones = '1;
		ka = {64'hA5A5_A5A5_A5A5_A5A5, 64'h0, 64'h0, 64'h1};
		kb = ka ^ (256'h1 << 255);
		kc = {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
		      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
		kd = ~kc;
		kfa = {64'h1, 64'h0, 64'h0, 64'h0};
		kfb = {64'h2, 64'h0, 64'h0, 64'h0};

		// flush with nothing netted, payload ignored
		plan(mk_word(rlnt_pkg::REQ_FLUSH, k_ones, '1, k_ones, '1), 1, 1'b1, zero_row);
		plan(mk_word(rlnt_pkg::REQ_LEG, k_ones, '1, '0, 64'h1), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_FLUSH, '0, '0, '0, '0), 1, 1'b1,
		     mk_row(1'b1, k_ones, '1, '0, 64'h1));
		// balanced entry only
		plan(mk_word(rlnt_pkg::REQ_LEG, kc, 64'd5, kc, 64'd5), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_FLUSH, '0, '0, '0, '0), 1, 1'b1, zero_row);
		// ties on both sides
		plan(mk_word(rlnt_pkg::REQ_LEG, ka, 64'd10, kb, 64'd10), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_LEG, kc, 64'd10, kd, 64'd10), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_FLUSH, '0, '0, '0, '0), 1, 1'b0, zero_row);
		// sums wrap
		plan(mk_word(rlnt_pkg::REQ_LEG, ka, '1, kb, '0), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_LEG, ka, 64'd2, kb, 64'd3), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_FLUSH, '0, '0, '0, '0), 1, 1'b0, zero_row);
		// paid side only
		plan(mk_word(rlnt_pkg::REQ_LEG, ka, 64'd7, ka, 64'd3), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_FLUSH, '0, '0, '0, '0), 1, 1'b1, zero_row);
		// zero amounts
		plan(mk_word(rlnt_pkg::REQ_LEG, kb, '0, ka, '0), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_FLUSH, '0, '0, '0, '0), 1, 1'b1, zero_row);
		// table exactly full, then full again with a new output key
		plan(mk_word(rlnt_pkg::REQ_LEG, kfa, 64'd100, kfb, 64'd90), NUM_ENTRIES / 2, 1'b0,
		     zero_row);
		plan(mk_word(rlnt_pkg::REQ_FLUSH, '0, '0, '0, '0), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_LEG, kfa, 64'd100, kfb, 64'd90), NUM_ENTRIES / 2, 1'b0,
		     zero_row);
		plan(mk_word(rlnt_pkg::REQ_LEG, kfa, 64'd1, kc, 64'd1), 1, 1'b0, zero_row);
		plan(mk_word(rlnt_pkg::REQ_FLUSH, '0, '0, '0, '0), 1, 1'b1, zero_row);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (leg_plan[p]) begin
			for (int r = 0; r < leg_plan[p].reps; r++) begin
				w = leg_plan[p].word;
				w.in_key_w0 += 64'(r);
				w.out_key_w0 += 64'(r);
				send_word(w, leg_plan[p].pinned, leg_plan[p].row);
			end
		end

		first_random = words_sent;
		while (words_sent - first_random < RANDOM_WORDS) begin
			if (!paused && words_sent - first_random > 150) begin
				// hold off until every row is back
				req_valid <= 1'b0;
				do @(negedge clk); while (row_q.size() != 0);
				paused = 1'b1;
			end
			if (!held && words_sent - first_random > 350) begin
				hold_rx = 1'b1;
				held = 1'b1;
			end
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				n = 0;
			end else if (kind <= 2) begin
				// fresh keys: fill exactly or overflow
				n = (kind == 1) ? $urandom_range(NUM_ENTRIES / 2 + 1, NUM_ENTRIES / 2 + 4)
				                : NUM_ENTRIES / 2;
				for (int i = 0; i < n; i++)
					send_word(mk_word(rlnt_pkg::REQ_LEG, rand_key(), rand_amt(), rand_key(),
					                  rand_amt()), 1'b0, zero_row);
			end else begin
				npool = $urandom_range(2, 6);
				pool[0] = rand_key();
				for (int i = 1; i < npool; i++) begin
					pool[i] = pool[0];
					case ($urandom_range(0, 2))
						0: pool[i][64*$urandom_range(0, 3) +: 64] = {$urandom, $urandom};
						1: pool[i][$urandom_range(0, KEY_W - 1)] ^= 1'b1;
						default: pool[i] = rand_key();
					endcase
				end
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++) begin
					ik = ($urandom_range(0, 9) == 0) ? rand_key() : pool[$urandom_range(0, npool - 1)];
					ok = ($urandom_range(0, 9) == 0) ? rand_key() : pool[$urandom_range(0, npool - 1)];
					send_word(mk_word(rlnt_pkg::REQ_LEG, ik, rand_amt(), ok, rand_amt()), 1'b0,
					          zero_row);
				end
			end
			send_word(mk_word(rlnt_pkg::REQ_FLUSH, rand_key(), rand_amt(), rand_key(), rand_amt()),
			          1'b0, zero_row);
		end

		req_valid <= 1'b0;
		do @(negedge clk); while (row_q.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("sent %0d words: %0d legs and %0d flushes, %0d of them after an overflow",
		         words_sent, legs_done, flushes_done, rows_ovf);
		$display("checked %0d rows, %0d of them netted", rows_checked, rows_netted);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
design/rlnt_pkg.sv
design/route_leg_netting_table.sv
tb/route_leg_netting_table_tb.sv
